// ===== design/hs_pkg.sv =====
// Shared types for the heap sorter block.
package hs_pkg;

    // Outcome of one key comparison in the configured order.
    typedef struct packed {
        logic after; // first key ranks after the second
        logic same;  // keys are equal
    } rank_t;

endpackage

// ===== design/heap_sorter.sv =====
// Heap sorter top level: load, in-place heapsort sequencer and result register.
//
// Usage: keys arrive on the in_valid/in_ready channel, one request per key;
// a request with last set closes the batch. The block stores up to MAX_ITEMS
// keys, drops any beyond that and flags overflow on every result of the batch.
// It then heap-sorts the batch in place and sends it on out_valid/out_ready,
// ascending, or descending when the descending bit (cfg_we/cfg_wdata) was set
// at the time the last key arrived. final_res marks the last result.
// in_ready is high only while keys are being loaded: one key per cycle.
// Sorting runs one shared comparator over one store read port: each heap
// level reads the left child and any right child, picks the child that ranks
// later, then compares it with the held key. Each result takes a store read,
// then a load of the output register. When the receiver stalls, the result
// is held in the output register and the sequencer waits; the next batch may
// start loading while the final result is still waiting. Reset empties the
// batch, clears the output valid and selects ascending order.
module heap_sorter #(
    parameter int MAX_ITEMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] key,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] sorted_key,
    output logic        final_res,
    output logic        overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LDH_RD   = 4'd1;
    localparam logic [3:0] S_LDH_WT   = 4'd2;
    localparam logic [3:0] S_EXT_RD0  = 4'd3;
    localparam logic [3:0] S_EXT_RD1  = 4'd4;
    localparam logic [3:0] S_EXT_WR   = 4'd5;
    localparam logic [3:0] S_SIFT     = 4'd6;
    localparam logic [3:0] S_SIFT_C1  = 4'd7;
    localparam logic [3:0] S_SIFT_C2  = 4'd8;
    localparam logic [3:0] S_SIFT_CMP = 4'd9;
    localparam logic [3:0] S_PUT      = 4'd10;
    localparam logic [3:0] S_EMIT_RD  = 4'd11;
    localparam logic [3:0] S_EMIT_LD  = 4'd12;

    logic [3:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  lost_reg, lost_next;
    logic                  desc_cfg_reg, desc_cfg_next;
    logic                  desc_sort_reg, desc_sort_next;
    logic                  build_reg, build_next;
    logic [CW-1:0]         outer_reg, outer_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         hn_reg, hn_next;
    logic [CW-1:0]         child_reg, child_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [DATA_WIDTH-1:0] held_reg, held_next;
    logic [DATA_WIDTH-1:0] ckey_reg, ckey_next;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_key_reg, out_key_next;
    logic                  out_final_reg, out_final_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [DATA_WIDTH-1:0] cmp_a, cmp_b;
    hs_pkg::rank_t         rank;

    logic [DATA_WIDTH-1:0] key_st;
    logic [CW:0]           child_l, child_r;
    logic [CW-1:0]         n_after;
    logic                  full;
    logic                  slot_free;
    logic                  emit_last;

    hs_ram #(
        .DEPTH (MAX_ITEMS),
        .DW    (DATA_WIDTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hs_rank #(
        .DW (DATA_WIDTH)
    ) u_rank (
        .desc (desc_sort_reg),
        .a    (cmp_a),
        .b    (cmp_b),
        .res  (rank)
    );

    assign key_st    = DATA_WIDTH'(64'(key));
    assign child_l   = (CW + 1)'(pos_reg) << 1;
    assign child_r   = child_l + (CW + 1)'(1);
    assign full      = (count_reg == CW'(MAX_ITEMS));
    assign n_after   = full ? count_reg : CW'(count_reg + 1'b1);
    assign slot_free = !out_valid_reg || out_ready;
    assign emit_last = (CW'(idx_reg + 1'b1) == count_reg);

    // Comparator input select: child against sibling, or held key against child.
    assign cmp_a = (state_reg == S_SIFT_C2) ? ckey_reg  : held_reg;
    assign cmp_b = (state_reg == S_SIFT_C2) ? ram_rdata : ckey_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lost_next      = lost_reg;
        desc_cfg_next  = cfg_we ? cfg_wdata : desc_cfg_reg;
        desc_sort_next = desc_sort_reg;
        build_next     = build_reg;
        outer_next     = outer_reg;
        pos_next       = pos_reg;
        hn_next        = hn_reg;
        child_next     = child_reg;
        idx_next       = idx_reg;
        held_next      = held_reg;
        ckey_next      = ckey_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_key_next   = out_key_reg;
        out_final_next = out_final_reg;
        out_ovf_next   = out_ovf_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = held_reg;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (full)
                    begin
                        lost_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = AW'(count_reg);
                        ram_wdata  = key_st;
                        count_next = n_after;
                    end
                    if (last)
                    begin
                        desc_sort_next = desc_cfg_reg;
                        idx_next       = '0;
                        if (n_after < CW'(2))
                        begin
                            state_next = S_EMIT_RD;
                        end
                        else
                        begin
                            build_next = 1'b1;
                            outer_next = n_after >> 1;
                            state_next = S_LDH_RD;
                        end
                    end
                end
            end
            S_LDH_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(outer_reg - 1'b1);
                state_next = S_LDH_WT;
            end
            S_LDH_WT:
            begin
                held_next  = ram_rdata;
                pos_next   = outer_reg;
                hn_next    = count_reg;
                state_next = S_SIFT;
            end
            S_EXT_RD0:
            begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = S_EXT_RD1;
            end
            S_EXT_RD1:
            begin
                ckey_next  = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = AW'(outer_reg - 1'b1);
                state_next = S_EXT_WR;
            end
            S_EXT_WR:
            begin
                // Move the root to the end of the heap, sift the displaced key.
                held_next  = ram_rdata;
                ram_we     = 1'b1;
                ram_waddr  = AW'(outer_reg - 1'b1);
                ram_wdata  = ckey_reg;
                pos_next   = CW'(1);
                hn_next    = CW'(outer_reg - 1'b1);
                state_next = S_SIFT;
            end
            S_SIFT:
            begin
                if (child_l > (CW + 1)'(hn_reg))
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(child_l - 1'b1);
                    state_next = S_SIFT_C1;
                end
            end
            S_SIFT_C1:
            begin
                ckey_next  = ram_rdata;
                child_next = CW'(child_l);
                if (child_r <= (CW + 1)'(hn_reg))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(child_l);
                    state_next = S_SIFT_C2;
                end
                else
                begin
                    state_next = S_SIFT_CMP;
                end
            end
            S_SIFT_C2:
            begin
                // Take the right child unless the left one ranks after it.
                if (!rank.after)
                begin
                    ckey_next  = ram_rdata;
                    child_next = CW'(child_r);
                end
                state_next = S_SIFT_CMP;
            end
            S_SIFT_CMP:
            begin
                if (rank.after || rank.same)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(pos_reg - 1'b1);
                    ram_wdata  = ckey_reg;
                    pos_next   = child_reg;
                    state_next = S_SIFT;
                end
            end
            S_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(pos_reg - 1'b1);
                ram_wdata = held_reg;
                if (build_reg)
                begin
                    if (outer_reg > CW'(1))
                    begin
                        outer_next = CW'(outer_reg - 1'b1);
                        state_next = S_LDH_RD;
                    end
                    else
                    begin
                        build_next = 1'b0;
                        outer_next = count_reg;
                        state_next = S_EXT_RD0;
                    end
                end
                else if (outer_reg > CW'(2))
                begin
                    outer_next = CW'(outer_reg - 1'b1);
                    state_next = S_EXT_RD0;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(idx_reg);
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = 32'(64'(ram_rdata));
                    out_final_next = emit_last;
                    out_ovf_next   = lost_reg;
                    idx_next       = CW'(idx_reg + 1'b1);
                    if (emit_last)
                    begin
                        count_next = '0;
                        lost_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lost_reg      <= 1'b0;
            desc_cfg_reg  <= 1'b0;
            desc_sort_reg <= 1'b0;
            build_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lost_reg      <= lost_next;
            desc_cfg_reg  <= desc_cfg_next;
            desc_sort_reg <= desc_sort_next;
            build_reg     <= build_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outer_reg     <= outer_next;
        pos_reg       <= pos_next;
        hn_reg        <= hn_next;
        child_reg     <= child_next;
        idx_reg       <= idx_next;
        held_reg      <= held_next;
        ckey_reg      <= ckey_next;
        out_key_reg   <= out_key_next;
        out_final_reg <= out_final_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sorted_key = out_key_reg;
    assign final_res  = out_final_reg;
    assign overflow   = out_ovf_reg;

    // Batch never holds more keys than the store.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("batch count beyond store depth");

    // Dropped keys only happen once the store is full.
    a_lost_full: assert property (@(posedge clk) disable iff (!rst_n)
        lost_reg |-> full)
        else $error("overflow flagged with room left");

    // Sift position stays inside the live heap.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIFT || state_reg == S_PUT) |->
        (pos_reg >= CW'(1) && pos_reg <= hn_reg))
        else $error("sift position outside heap");

    // Loading the final result empties the batch and reopens the input.
    a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD && slot_free && emit_last) |=>
        (state_reg == S_IDLE && count_reg == '0 && out_valid_reg && final_res))
        else $error("batch not closed after final result");

endmodule

// ===== design/hs_ram.sv =====
// Key store: one write port and one registered read port.
module hs_ram #(
    parameter int DEPTH = 64,
    parameter int DW    = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/hs_rank.sv =====
// Shared key comparator; the direction bit flips ascending to descending order.
module hs_rank #(
    parameter int DW = 32
) (
    input  logic          desc,
    input  logic [DW-1:0] a,
    input  logic [DW-1:0] b,
    output hs_pkg::rank_t res
);

    always_comb
    begin
        res.same  = (a == b);
        res.after = desc ? (a < b) : (a > b);
    end

endmodule
